// File: rtl/gms_pkg.sv
// ----------------------------------------------------------------------------
// gms_pkg
// Shared types and codes for the gradient magnitude stencil.
// ----------------------------------------------------------------------------
package gms_pkg;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [1:0] CFG_MODE_3D      = 2'd0;
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

  localparam int CFG_DATA_BITS = 16;

  typedef struct packed {
    logic        req_type;
    logic [15:0] cur_sample;
    logic [15:0] prev_slice_sample;
    logic [15:0] next_slice_sample;
  } in_word_t;

  typedef struct packed {
    logic [16:0] magnitude;
    logic [9:0]  out_x;
    logic [15:0] out_y;
    logic        last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic rd1;
    logic rd2;
    logic wr;
    logic sq;
    logic go;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_work;
    logic has_res;
    logic root_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

// File: rtl/gms_isqrt.sv
// ----------------------------------------------------------------------------
// gms_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module gms_isqrt #(
  parameter int NB = 34
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NB-1:0]     n,
  output logic              done,
  output logic [NB/2-1:0]   root
);

  localparam int HB = NB / 2;
  localparam int RW = HB + 2;
  localparam int CW = $clog2(HB + 1);

  logic [NB-1:0] val;
  logic [RW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;

  assign rem_sh = {rem[RW-3:0], val[NB-1:NB-2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        val  <= n;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        val <= {val[NB-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[HB-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[HB-2:0], 1'b0};
        end
        if (cnt == CW'(HB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

// File: rtl/gms_ctrl.sv
// ----------------------------------------------------------------------------
// gms_ctrl
// Sequencer: read, update, square and root steps for one word at a time.
// ----------------------------------------------------------------------------
module gms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gms_pkg::ctrl_stat_t stat,
  output gms_pkg::ctrl_cmd_t  cmd
);
  import gms_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD1, S_RD2, S_WR, S_SQ, S_GO, S_ROOT, S_OUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd      = '0;
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.rd1  = (state == S_RD1);
    cmd.rd2  = (state == S_RD2);
    cmd.wr   = (state == S_WR);
    cmd.sq   = (state == S_SQ);
    cmd.go   = (state == S_GO);
    cmd.emit = (state == S_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid && !stat.no_work) state <= S_RD1;
        S_RD1:  state <= S_RD2;
        S_RD2:  state <= S_WR;
        S_WR:   state <= stat.has_res ? S_SQ : S_IDLE;
        S_SQ:   state <= S_GO;
        S_GO:   state <= S_ROOT;
        S_ROOT: if (stat.root_done) state <= S_OUT;
        S_OUT:  if (stat.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/gms_dp.sv
// ----------------------------------------------------------------------------
// gms_dp
// Datapath: line buffers, counters, differences, squares, root, output word.
// ----------------------------------------------------------------------------
module gms_dp #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  gms_pkg::in_word_t   in_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  gms_pkg::ctrl_cmd_t  cmd,
  output gms_pkg::ctrl_stat_t stat,
  output logic                out_valid,
  input  logic                out_ready,
  output gms_pkg::out_word_t  out_word
);
  import gms_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int NB = 2 * SB + 2;

  logic              mode_3d;
  logic [10:0]       frame_width;
  logic [15:0]       frame_height;
  logic [WW-1:0]     w;
  logic [15:0]       h;

  logic [SB-1:0]        row_above  [MAX_WIDTH];
  logic [SB-1:0]        row_middle [MAX_WIDTH];
  logic signed [SB:0]   z_diff_line [MAX_WIDTH];

  logic [WW-1:0]     col, pend;
  logic [15:0]       row;
  logic [SB-1:0]     pw0;

  logic              flush_q, has_res, last_q, idx_zero, right_ok, y_zero;
  logic [AW-1:0]     idx;
  logic [15:0]       y_q;
  logic [SB-1:0]     cur_q;
  logic signed [SB:0] zd_new;
  logic [SB-1:0]     mid_a, mid_b, left_q, above_q;
  logic signed [SB:0] z_q;
  logic signed [SB:0] gx, gy, gz;
  logic [2*SB-1:0]   sqx, sqy, sqz;
  logic [AW-1:0]     addr_b;

  logic [WW-1:0]     c0, pc, d0;
  logic [16:0]       rinc;
  logic [15:0]       r0;
  logic [WW:0]       c1;
  logic [16:0]       r1;
  logic [SB-1:0]     cur_in, pz_in, nz_in;
  logic [SB-1:0]     up_v, left_v, right_v, down_v;
  logic signed [2*SB+1:0] px, py, pzq;
  logic [NB-1:0]     sum_v;
  logic              root_done;
  logic [SB:0]       root;

  always_comb begin
    if (frame_width == 11'd0) w = WW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(frame_width);
    h = (frame_height == 16'd0) ? 16'd1 : frame_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_3d      <= 1'b0;
      frame_width  <= 11'd1024;
      frame_height <= 16'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE_3D:      mode_3d      <= cfg_data[0];
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_in = SB'(in_word.cur_sample);
    pz_in  = SB'(in_word.prev_slice_sample);
    nz_in  = SB'(in_word.next_slice_sample);
    c0     = (col >= w) ? '0 : col;
    rinc   = (col >= w) ? {1'b0, row} + 17'd1 : {1'b0, row};
    r0     = (rinc >= {1'b0, h}) ? 16'd0 : rinc[15:0];
    pc     = (pend > w) ? w : pend;
    d0     = in_word.req_type == REQ_FLUSH ? w - pc : c0;
    c1     = {1'b0, WW'(idx)} + 1'b1;
    r1     = {1'b0, row} + 17'd1;
    stat.no_work = (in_word.req_type == REQ_FLUSH) && (pend == '0);
    stat.has_res = has_res;
    stat.root_done = root_done;
    stat.out_free  = !out_valid || out_ready;
  end

  always_comb begin
    up_v    = y_zero ? mid_a : above_q;
    left_v  = idx_zero ? mid_a : (flush_q ? left_q : pw0);
    right_v = right_ok ? mid_b : mid_a;
    down_v  = flush_q ? mid_a : cur_q;
    px      = gx * gx;
    py      = gy * gy;
    pzq     = gz * gz;
    sum_v   = NB'(sqx) + NB'(sqy) + (mode_3d ? NB'(sqz) : '0);
    addr_b  = cmd.rd2 ? idx - 1'b1 : idx + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      pend <= '0;
      pw0  <= '0;
    end else if (cmd.load) begin
      if (in_word.req_type == REQ_FLUSH) begin
        pend <= pc;
      end else begin
        pend <= '0;
        col  <= c0;
        row  <= r0;
      end
    end else if (cmd.wr) begin
      if (flush_q) begin
        pend <= pend - 1'b1;
      end else begin
        pw0 <= mid_a;
        if (c1 >= {1'b0, w}) begin
          col <= '0;
          if (r1 >= {1'b0, h}) begin
            row  <= '0;
            pend <= w;
          end else begin
            row <= r1[15:0];
          end
        end else begin
          col <= c1[WW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flush_q  <= (in_word.req_type == REQ_FLUSH);
      cur_q    <= cur_in;
      zd_new   <= $signed({1'b0, nz_in}) - $signed({1'b0, pz_in});
      idx      <= d0[AW-1:0];
      idx_zero <= (d0 == '0);
      right_ok <= ({1'b0, d0} + 1'b1) < {1'b0, w};
      last_q   <= (pc == WW'(1));
      if (in_word.req_type == REQ_FLUSH) begin
        y_q     <= h - 16'd1;
        y_zero  <= (h == 16'd1);
        has_res <= 1'b1;
      end else begin
        y_q     <= r0 - 16'd1;
        y_zero  <= (r0 == 16'd1);
        has_res <= (r0 != 16'd0);
      end
    end
    if (cmd.wr) begin
      gx <= $signed({1'b0, right_v}) - $signed({1'b0, left_v});
      gy <= $signed({1'b0, down_v}) - $signed({1'b0, up_v});
      gz <= z_q;
    end
    if (cmd.sq) begin
      sqx <= px[2*SB-1:0];
      sqy <= py[2*SB-1:0];
      sqz <= pzq[2*SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd1) begin
      mid_a   <= row_middle[idx];
      above_q <= row_above[idx];
      z_q     <= z_diff_line[idx];
    end
    if (cmd.rd1) mid_b  <= row_middle[addr_b];
    if (cmd.rd2) left_q <= row_middle[addr_b];
    if (cmd.wr && !flush_q) begin
      row_above[idx]   <= mid_a;
      row_middle[idx]  <= cur_q;
      z_diff_line[idx] <= zd_new;
    end
  end

  gms_isqrt #(.NB(NB)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.go),
    .n     (sum_v),
    .done  (root_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word.magnitude     <= 17'(root);
      out_word.out_x         <= 10'(idx);
      out_word.out_y         <= y_q;
      out_word.last_of_frame <= flush_q && last_q;
    end
  end

endmodule

// File: rtl/gradient_magnitude_stencil.sv
// ----------------------------------------------------------------------------
// gradient_magnitude_stencil
// Central-difference gradient magnitude over a raster sample stream.
// ----------------------------------------------------------------------------
// Input words carry a pixel (current, previous-slice and next-slice samples)
// or a flush tick. A pixel's result (Q17.0 magnitude, column, row) leaves when
// the pixel below it arrives; after the last row of a slice, one flush word
// per column drains the held row, the final one marked last_of_frame.
// Words are handled one at a time: a word with no result passes RD1, RD2 and
// WR (a flush with nothing pending is taken in idle); one with a result goes
// on through SQ, GO, ROOT and OUT, the bit-serial square root giving one root
// bit per cycle. The three line buffers are single-write RAMs, read in RD1 and
// RD2. The result sits in an output register; the next word is taken while it
// waits, and the sequencer stalls only when a new result meets a full output
// register. Configuration writes take effect at once.
// Reset clears counters and configuration (2D, 1024 x 1024); line buffer
// contents are undefined until written and need no clearing.
// ----------------------------------------------------------------------------
module gradient_magnitude_stencil #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gms_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output gms_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import gms_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  gms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gms_dp #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// File: sim/gradient_magnitude_stencil_test.sv
// ----------------------------------------------------------------------------
// gradient_magnitude_stencil_test
// Self-checking bench for the gradient magnitude stencil.
// ----------------------------------------------------------------------------
// Drives slices of random sizes in 2D and 3D mode, with flush ticks to drain
// the last row. Sizes also go out of range and are cut back mid-slice.
// A scoreboard predicts each result word from the accepted input words and
// compares every result word field by field, in order. Both sides idle in
// random bursts. The output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module gradient_magnitude_stencil_test;
  import gms_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  class gms_scoreboard;
    bit          mode3d;
    int unsigned width_reg, height_reg;
    logic [15:0] above [1024];
    logic [15:0] middle [1024];
    int          zdiff [1024];
    int unsigned col, row, pend;
    logic [15:0] left_old;
    out_word_t   expq [$];
    int          errors;

    function new();
      mode3d = 0;
      width_reg = 1024;
      height_reg = 1024;
      for (int i = 0; i < 1024; i++) begin
        above[i] = '0;
        middle[i] = '0;
        zdiff[i] = 0;
      end
      col = 0;
      row = 0;
      pend = 0;
      left_old = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_MODE_3D: mode3d = val[0];
        CFG_FRAME_WIDTH: width_reg = val[10:0];
        CFG_FRAME_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    function logic [16:0] root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 40;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res[16:0];
    endfunction

    function logic [16:0] grad(int l, int r, int u, int d, int z);
      longint gx, gy, gz, sum;
      gx = r - l;
      gy = d - u;
      gz = z;
      sum = gx * gx + gy * gy;
      if (mode3d) sum = sum + gz * gz;
      return root(sum);
    endfunction

    function void note_input(in_word_t w);
      int unsigned wd, ht, c, r, d, y;
      logic [15:0] oldc, up, lf, rt, mid;
      out_word_t e;
      wd = (width_reg == 0) ? 1 : (width_reg > 1024) ? 1024 : width_reg;
      ht = (height_reg == 0) ? 1 : height_reg;
      if (w.req_type == REQ_FLUSH) begin
        if (pend == 0) return;
        if (pend > wd) pend = wd;
        d = wd - pend;
        y = ht - 1;
        mid = middle[d];
        up = (y == 0) ? mid : above[d];
        lf = (d == 0) ? mid : middle[d - 1];
        rt = (d + 1 < wd) ? middle[d + 1] : mid;
        pend--;
        e.magnitude = grad(lf, rt, up, mid, zdiff[d]);
        e.out_x = d[9:0];
        e.out_y = y[15:0];
        e.last_of_frame = (pend == 0);
        expq.push_back(e);
        return;
      end
      pend = 0;
      if (col >= wd) begin
        col = 0;
        row++;
      end
      if (row >= ht) row = 0;
      c = col;
      r = row;
      oldc = middle[c];
      if (r >= 1) begin
        y = r - 1;
        up = (y == 0) ? oldc : above[c];
        lf = (c == 0) ? oldc : left_old;
        rt = (c + 1 < wd) ? middle[c + 1] : oldc;
        e.magnitude = grad(lf, rt, up, w.cur_sample, zdiff[c]);
        e.out_x = c[9:0];
        e.out_y = y[15:0];
        e.last_of_frame = 1'b0;
        expq.push_back(e);
      end
      left_old = oldc;
      above[c] = oldc;
      middle[c] = w.cur_sample;
      zdiff[c] = int'(w.next_slice_sample) - int'(w.prev_slice_sample);
      col = c + 1;
      if (col >= wd) begin
        col = 0;
        row = r + 1;
        if (row >= ht) begin
          row = 0;
          pend = wd;
        end
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (expq.size() == 0) begin
        $display("%0t: unexpected result word, actual %h", $time, got);
        errors++;
        return;
      end
      e = expq.pop_front();
      if (got.magnitude !== e.magnitude) begin
        $display("%0t: magnitude expected %0d actual %0d", $time, e.magnitude, got.magnitude);
        errors++;
      end
      if (got.out_x !== e.out_x) begin
        $display("%0t: out_x expected %0d actual %0d", $time, e.out_x, got.out_x);
        errors++;
      end
      if (got.out_y !== e.out_y) begin
        $display("%0t: out_y expected %0d actual %0d", $time, e.out_y, got.out_y);
        errors++;
      end
      if (got.last_of_frame !== e.last_of_frame) begin
        $display("%0t: last_of_frame expected %0d actual %0d", $time, e.last_of_frame,
                 got.last_of_frame);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  in_word_t    in_word;
  out_word_t   out_word;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  gms_scoreboard sb;
  int  sent;
  bit  quiet, hold_now;
  int  idle_cnt;

  gradient_magnitude_stencil u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_word);
      if (out_valid && out_ready) sb.check_result(out_word);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    @(negedge rst);
    forever begin
      if (hold_now) begin
        hold_now = 0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(in_word_t w);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (sent > 1700) quiet = 1;
  endtask

  task automatic send_pixel(logic [15:0] s, logic [15:0] pz, logic [15:0] nz);
    in_word_t w;
    w.req_type = REQ_PIXEL;
    w.cur_sample = s;
    w.prev_slice_sample = pz;
    w.next_slice_sample = nz;
    send_word(w);
  endtask

  task automatic send_flush();
    in_word_t w;
    w.req_type = REQ_FLUSH;
    w.cur_sample = 16'($urandom);
    w.prev_slice_sample = 16'($urandom);
    w.next_slice_sample = 16'($urandom);
    send_word(w);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expq.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic setup(bit m, logic [15:0] wd, logic [15:0] ht);
    settle();
    cfg_write(CFG_MODE_3D, {15'd0, m});
    cfg_write(CFG_FRAME_WIDTH, wd);
    cfg_write(CFG_FRAME_HEIGHT, ht);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_pixel();
    if ($urandom_range(0, 31) == 0) send_flush();
    send_pixel(rand_sample(), rand_sample(), rand_sample());
  endtask

  initial begin
    int unsigned wd, ht, k;
    int phase;
    sb = new();
    clk = 0;
    rst = 1;
    in_valid = 0;
    in_word = '0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    sent = 0;
    quiet = 0;
    hold_now = 0;
    idle_cnt = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 3x2 slice in 3D with extreme samples
    setup(1'b1, 16'd3, 16'd2);
    send_pixel(16'h0000, 16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'h0000);
    send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
    send_pixel(16'h0000, 16'h5555, 16'hAAAA);
    send_pixel(16'hFFFF, 16'hAAAA, 16'h5555);
    repeat (4) send_flush();
    // single pixel frame, flush with nothing pending, pixel dropping pending
    setup(1'b0, 16'd1, 16'd1);
    send_pixel(16'hFFFF, 16'h0000, 16'hFFFF);
    send_flush();
    send_flush();
    send_pixel(16'h1234, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'hFFFF, 16'hFFFF);
    send_flush();
    // zero sizes are taken as one
    setup(1'b1, 16'd0, 16'd0);
    send_pixel(16'h8000, 16'hFFFF, 16'h0000);
    send_flush();
    // width above maximum: one full row, then part of the next
    setup(1'b1, 16'd2047, 16'd2);
    for (int i = 0; i < 1024 + 16; i++) send_pixel(rand_sample(), rand_sample(), rand_sample());

    phase = 0;
    while (sent < 2000) begin
      bit m;
      m = 1'($urandom_range(0, 1));
      wd = $urandom_range(1, 12);
      ht = $urandom_range(1, 5);
      if (phase == 3) begin
        // tall slice cut short, then width and height cut below the counters
        wd = $urandom_range(4, 12);
        setup(m, 16'(wd), 16'd65535);
        for (int i = 0; i < 2 * wd + wd / 2; i++) random_pixel();
        k = wd / 2;
        setup(m, 16'(k), 16'd1);
        wd = k;
        ht = 1;
      end else begin
        setup(m, 16'(wd), 16'(ht));
      end
      if (phase == 2) hold_now = 1;
      for (int s = $urandom_range(1, 3); s > 0; s--) begin
        for (int i = 0; i < wd * ht; i++) random_pixel();
        if ($urandom_range(0, 3) == 0) k = $urandom_range(0, wd);
        else k = wd + $urandom_range(0, 2);
        repeat (k) send_flush();
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expq.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// File: gradient_magnitude_stencil.f
rtl/gms_pkg.sv
rtl/gms_isqrt.sv
rtl/gms_ctrl.sv
rtl/gms_dp.sv
rtl/gradient_magnitude_stencil.sv
sim/gradient_magnitude_stencil_test.sv
